### hdl/grb_pkg.sv
// ----------------------------------------------------------------------------
// grb_pkg
// Shared widths, word map codes and transfer structs of the GPIO register block.
// ----------------------------------------------------------------------------
`default_nettype none

package grb_pkg;

	// field widths of one bus access and one result
	localparam int WORD_W   = 6;
	localparam int DATA_W   = 32;
	localparam int PAD_W    = 40;
	localparam int LEVEL_W  = 40;
	localparam int PULL_W   = 34;
	localparam int FUNC_W   = 3;
	localparam int MUXRD_W  = 8;

	// stream packing
	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 184;
	localparam int M_TUSER_W = 1;

	// mux word bit positions
	localparam int MUX_PD_BIT = 6;
	localparam int MUX_PU_BIT = 7;

	// gpio word map, word index = byte offset / 4
	localparam logic [WORD_W-1:0] W_OUT_LO     = 6'd1;
	localparam logic [WORD_W-1:0] W_OUT_LO_SET = 6'd2;
	localparam logic [WORD_W-1:0] W_OUT_LO_CLR = 6'd3;
	localparam logic [WORD_W-1:0] W_OUT_HI     = 6'd4;
	localparam logic [WORD_W-1:0] W_OUT_HI_SET = 6'd5;
	localparam logic [WORD_W-1:0] W_OUT_HI_CLR = 6'd6;
	localparam logic [WORD_W-1:0] W_OE_LO      = 6'd8;
	localparam logic [WORD_W-1:0] W_OE_LO_SET  = 6'd9;
	localparam logic [WORD_W-1:0] W_OE_LO_CLR  = 6'd10;
	localparam logic [WORD_W-1:0] W_OE_HI      = 6'd11;
	localparam logic [WORD_W-1:0] W_OE_HI_SET  = 6'd12;
	localparam logic [WORD_W-1:0] W_OE_HI_CLR  = 6'd13;
	localparam logic [WORD_W-1:0] W_IN_LO      = 6'd15;
	localparam logic [WORD_W-1:0] W_IN_HI      = 6'd16;

	// one bus access held in the input stage
	typedef struct packed {
		logic              wr;
		logic              mux;
		logic [WORD_W-1:0] word;
		logic [DATA_W-1:0] data;
		logic [PAD_W-1:0]  pads;
	} grb_req_t;

	// write into the pin mux settings
	typedef struct packed {
		logic              wr_en;
		logic [WORD_W-1:0] pin;
		logic [FUNC_W-1:0] func;
		logic              pd;
		logic              pu;
	} grb_mux_wr_t;

endpackage

`default_nettype wire

### hdl/gpio_register_block.sv
// ----------------------------------------------------------------------------
// gpio_register_block
// GPIO output and enable registers with set and clear words, plus pin mux words.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the s_axis channel is one bus access: tuser carries the
// operation and the region, tdata the word offset, the write data and the
// sampled pad levels. For every access exactly one result leaves on m_axis:
// the read word, the pin drive levels and enables, the pull-up and pull-down
// enables as they stand after the access, and a bad address flag in tuser.
// The accepting edge loads the input stage, which decodes the access and
// updates the registers; the result register then loads once it is free and
// raises m_axis_tvalid. Throughput is one access per clock while the receiver
// does not stall; the function-select RAM read is issued at acceptance and a
// write to the same pin in that edge is forwarded.
// Reset clears all output, enable and pull bits and marks every mux entry as
// function zero at once; no clearing pass is needed.
// When the receiver stalls the result register holds, the input stage holds
// one more access, and s_axis_tready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_register_block
	import grb_pkg::*;
#(
	parameter int PIN_COUNT     = 40,
	parameter int MUX_PIN_COUNT = 34
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// word_offset[5:0], write_data[37:6], pad_levels[77:38], zero fill
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	// operation[0], region[1]
	input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// read_data[31:0], drive_levels[71:32], drive_enables[111:72],
	// pullup_enables[145:112], pulldown_enables[179:146], zero fill
	output logic      [M_TDATA_W-1:0] m_axis_tdata,
	// bad_address[0]
	output logic      [M_TUSER_W-1:0] m_axis_tuser
);

	grb_req_t          req_s1;
	logic              s1_valid_q;
	logic              out_valid_q;
	logic              accept, commit;
	logic              mux_hit;
	logic [DATA_W-1:0] gpio_rd, rd_word;
	logic              gpio_hit, bad;
	logic [MUXRD_W-1:0] mux_rd;
	logic [LEVEL_W-1:0] levels, enables;
	logic [PULL_W-1:0] pullups, pulldowns;
	grb_mux_wr_t       mux_wr;
	logic [M_TDATA_W-1:0] data_q;
	logic              bad_q;

	// handshake
	assign commit        = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || commit;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.wr   <= s_axis_tuser[0];
			req_s1.mux  <= s_axis_tuser[1];
			req_s1.word <= s_axis_tdata[WORD_W-1:0];
			req_s1.data <= s_axis_tdata[WORD_W+DATA_W-1:WORD_W];
			req_s1.pads <= s_axis_tdata[WORD_W+DATA_W+PAD_W-1:WORD_W+DATA_W];
		end
	end

	// mux range check and write
	assign mux_hit = req_s1.mux && ({1'b0, req_s1.word} < (WORD_W+1)'(MUX_PIN_COUNT));

	always_comb begin
		mux_wr.wr_en = commit && mux_hit && req_s1.wr;
		mux_wr.pin   = req_s1.word;
		mux_wr.func  = req_s1.data[FUNC_W-1:0];
		mux_wr.pd    = req_s1.data[MUX_PD_BIT];
		mux_wr.pu    = req_s1.data[MUX_PU_BIT];
	end

	grb_gpio_bank #(
		.PIN_COUNT (PIN_COUNT)
	) u_gpio (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.req          (req_s1),
		.rd_word      (gpio_rd),
		.hit          (gpio_hit),
		.levels_next  (levels),
		.enables_next (enables)
	);

	grb_mux_bank #(
		.MUX_PIN_COUNT (MUX_PIN_COUNT)
	) u_mux (
		.clk            (clk),
		.arst_n         (arst_n),
		.rd_en          (accept),
		.rd_pin         (s_axis_tdata[WORD_W-1:0]),
		.s1_pin         (req_s1.word),
		.s1_in_range    (mux_hit),
		.wr             (mux_wr),
		.rd_word        (mux_rd),
		.pullups_next   (pullups),
		.pulldowns_next (pulldowns)
	);

	// read word and error flag
	always_comb begin
		if (req_s1.mux) begin
			rd_word = DATA_W'(mux_rd);
			bad     = !mux_hit;
		end else begin
			rd_word = gpio_rd;
			bad     = !gpio_hit;
		end
		if (req_s1.wr) begin
			rd_word = '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			data_q <= {4'b0, pulldowns, pullups, enables, levels, rd_word};
			bad_q  <= bad;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = data_q;
	assign m_axis_tuser[0] = bad_q;

	// an unmapped access never returns data
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[DATA_W-1:0] == '0)
		else $error("unmapped access returned data");

	// writes read back zero
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		commit && req_s1.wr |=> m_axis_tdata[DATA_W-1:0] == '0)
		else $error("write returned data");

	// the input stage moves into the result register when it is free
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && (!out_valid_q || m_axis_tready) |=> m_axis_tvalid)
		else $error("access did not reach the result register");

endmodule

`default_nettype wire

### hdl/grb_ram.sv
// ----------------------------------------------------------------------------
// grb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module grb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/grb_gpio_bank.sv
// ----------------------------------------------------------------------------
// grb_gpio_bank
// Output level and output enable banks with set and clear words, word decode.
// ----------------------------------------------------------------------------
`default_nettype none

module grb_gpio_bank
	import grb_pkg::*;
#(
	parameter int PIN_COUNT = 40
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              commit,
	input  wire grb_req_t          req,
	output logic      [DATA_W-1:0] rd_word,
	output logic                   hit,
	output logic      [LEVEL_W-1:0] levels_next,
	output logic      [LEVEL_W-1:0] enables_next
);

	localparam int HIGH_W = PIN_COUNT - 32;
	localparam logic [DATA_W-1:0] HIGH_MASK = DATA_W'((64'd1 << HIGH_W) - 64'd1);

	logic [31:0]       out_lo_q, out_lo_d;
	logic [HIGH_W-1:0] out_hi_q, out_hi_d;
	logic [31:0]       oe_lo_q, oe_lo_d;
	logic [HIGH_W-1:0] oe_hi_q, oe_hi_d;
	logic [HIGH_W-1:0] data_hi;
	logic              upd;

	assign data_hi = req.data[HIGH_W-1:0];
	assign upd     = req.wr && !req.mux;

	// word decode and next bank values
	always_comb begin
		out_lo_d = out_lo_q;
		out_hi_d = out_hi_q;
		oe_lo_d  = oe_lo_q;
		oe_hi_d  = oe_hi_q;
		rd_word  = '0;
		hit      = 1'b1;
		case (req.word)
			W_OUT_LO: begin
				if (upd) out_lo_d = req.data;
				else rd_word = out_lo_q;
			end
			W_OUT_LO_SET: if (upd) out_lo_d = out_lo_q | req.data;
			W_OUT_LO_CLR: if (upd) out_lo_d = out_lo_q & ~req.data;
			W_OUT_HI: begin
				if (upd) out_hi_d = data_hi;
				else rd_word = DATA_W'(out_hi_q);
			end
			W_OUT_HI_SET: if (upd) out_hi_d = out_hi_q | data_hi;
			W_OUT_HI_CLR: if (upd) out_hi_d = out_hi_q & ~data_hi;
			W_OE_LO: begin
				if (upd) oe_lo_d = req.data;
				else rd_word = oe_lo_q;
			end
			W_OE_LO_SET: if (upd) oe_lo_d = oe_lo_q | req.data;
			W_OE_LO_CLR: if (upd) oe_lo_d = oe_lo_q & ~req.data;
			W_OE_HI: begin
				if (upd) oe_hi_d = data_hi;
				else rd_word = DATA_W'(oe_hi_q);
			end
			W_OE_HI_SET: if (upd) oe_hi_d = oe_hi_q | data_hi;
			W_OE_HI_CLR: if (upd) oe_hi_d = oe_hi_q & ~data_hi;
			W_IN_LO: rd_word = req.pads[31:0];
			W_IN_HI: rd_word = DATA_W'(req.pads[PAD_W-1:32]) & HIGH_MASK;
			default: hit = 1'b0;
		endcase
	end

	// bank registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_lo_q <= '0;
			out_hi_q <= '0;
			oe_lo_q  <= '0;
			oe_hi_q  <= '0;
		end else if (commit) begin
			out_lo_q <= out_lo_d;
			out_hi_q <= out_hi_d;
			oe_lo_q  <= oe_lo_d;
			oe_hi_q  <= oe_hi_d;
		end
	end

	// pin view after this access
	assign levels_next  = LEVEL_W'({out_hi_d, out_lo_d});
	assign enables_next = LEVEL_W'({oe_hi_d, oe_lo_d});

	// a clear word leaves none of its mask bits set
	a_clear_lo: assert property (@(posedge clk) disable iff (!arst_n)
		commit && upd && req.word == W_OUT_LO_CLR |=> (out_lo_q & $past(req.data)) == '0)
		else $error("output clear word left bits set");

	a_set_oe: assert property (@(posedge clk) disable iff (!arst_n)
		commit && upd && req.word == W_OE_LO_SET |=> (oe_lo_q & $past(req.data)) == $past(req.data))
		else $error("enable set word missed bits");

endmodule

`default_nettype wire

### hdl/grb_mux_bank.sv
// ----------------------------------------------------------------------------
// grb_mux_bank
// Per-pin mux settings: function bits in RAM, pull bits and valid bits in flops.
// ----------------------------------------------------------------------------
`default_nettype none

module grb_mux_bank
	import grb_pkg::*;
#(
	parameter int MUX_PIN_COUNT = 34
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_en,
	input  wire logic [WORD_W-1:0]  rd_pin,
	input  wire logic [WORD_W-1:0]  s1_pin,
	input  wire logic               s1_in_range,
	input  wire grb_mux_wr_t        wr,
	output logic      [MUXRD_W-1:0] rd_word,
	output logic      [PULL_W-1:0]  pullups_next,
	output logic      [PULL_W-1:0]  pulldowns_next
);

	localparam int AW = (MUX_PIN_COUNT > 1) ? $clog2(MUX_PIN_COUNT) : 1;

	logic [MUX_PIN_COUNT-1:0] valid_q;
	logic [MUX_PIN_COUNT-1:0] pu_q, pu_d;
	logic [MUX_PIN_COUNT-1:0] pd_q, pd_d;
	logic [FUNC_W-1:0]        ram_rdata;
	logic                     fwd_q;
	logic [FUNC_W-1:0]        fwd_func_q;
	logic [FUNC_W-1:0]        func;
	logic [AW-1:0]            s1_idx, wr_idx;

	assign s1_idx = s1_pin[AW-1:0];
	assign wr_idx = wr.pin[AW-1:0];

	// function select storage, read issued when an access is accepted
	grb_ram #(
		.WIDTH (FUNC_W),
		.DEPTH (MUX_PIN_COUNT)
	) u_func_ram (
		.clk     (clk),
		.wr_en   (wr.wr_en),
		.wr_addr (wr_idx),
		.wr_data (wr.func),
		.rd_en   (rd_en),
		.rd_addr (rd_pin[AW-1:0]),
		.rd_data (ram_rdata)
	);

	// forward a write that lands in the same edge as the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr.wr_en && (wr.pin == rd_pin);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_func_q <= wr.func;
		end
	end

	// never-written entries read as function zero
	always_comb begin
		func = '0;
		if (s1_in_range && valid_q[s1_idx]) begin
			func = fwd_q ? fwd_func_q : ram_rdata;
		end
	end

	// readback word for the access in the input stage
	always_comb begin
		rd_word = '0;
		if (s1_in_range) begin
			rd_word[FUNC_W-1:0]  = func;
			rd_word[MUX_PD_BIT]  = pd_q[s1_idx];
			rd_word[MUX_PU_BIT]  = pu_q[s1_idx];
		end
	end

	// pull bits after this access
	always_comb begin
		pu_d = pu_q;
		pd_d = pd_q;
		if (wr.wr_en) begin
			pu_d[wr_idx] = wr.pu;
			pd_d[wr_idx] = wr.pd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pu_q    <= '0;
			pd_q    <= '0;
		end else if (wr.wr_en) begin
			valid_q[wr_idx] <= 1'b1;
			pu_q            <= pu_d;
			pd_q            <= pd_d;
		end
	end

	assign pullups_next   = PULL_W'(pu_d);
	assign pulldowns_next = PULL_W'(pd_d);

	// a written entry is valid and holds the written pull-up bit
	a_mux_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr.wr_en |=> valid_q[$past(wr_idx)] && pu_q[$past(wr_idx)] == $past(wr.pu))
		else $error("mux write not stored");

endmodule

`default_nettype wire

### dv/gpio_register_block_test.sv
// ----------------------------------------------------------------------------
// gpio_register_block_test
// Self-checking stream testbench for the GPIO register block. A directed set
// of accesses covers every word of the GPIO region, the set and clear words, the
// high bank truncation, mux unused bits and unmapped words; random accesses
// follow. Each transaction is predicted in the testbench and every result is
// compared field by field, with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_register_block_test;
	import grb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// high bank width and mux pin count of the default configuration
	localparam int HI_W      = PAD_W - 32;
	localparam int MUX_PINS  = PULL_W;
	localparam int RANDOM_N  = 1100;
	localparam int IDLE_MAX  = 4000;
	localparam int DRAIN_CYC = 8;

	// result field positions inside m_axis_tdata
	localparam int LEVEL_LSB  = DATA_W;
	localparam int ENABLE_LSB = LEVEL_LSB + LEVEL_W;
	localparam int PU_LSB     = ENABLE_LSB + LEVEL_W;
	localparam int PD_LSB     = PU_LSB + PULL_W;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} access_op_e;

	typedef enum logic {
		RGN_GPIO = 1'b0,
		RGN_MUX  = 1'b1
	} access_region_e;

	typedef struct packed {
		access_op_e        op;
		access_region_e    region;
		logic [WORD_W-1:0] word;
		logic [DATA_W-1:0] data;
		logic [PAD_W-1:0]  pads;
		logic              wait_drain;
	} bus_access_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic [LEVEL_W-1:0] levels;
		logic [LEVEL_W-1:0] enables;
		logic [PULL_W-1:0]  pullups;
		logic [PULL_W-1:0]  pulldowns;
		logic               bad_address;
	} pin_readback_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [M_TUSER_W-1:0] m_axis_tuser;

	gpio_register_block u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// shadow copy of the block's registers
	logic [DATA_W-1:0] out_lo = '0;
	logic [HI_W-1:0]   out_hi = '0;
	logic [DATA_W-1:0] oe_lo  = '0;
	logic [HI_W-1:0]   oe_hi  = '0;
	logic [FUNC_W-1:0] mux_func [MUX_PINS];
	logic [PULL_W-1:0] mux_pu = '0;
	logic [PULL_W-1:0] mux_pd = '0;

	bus_access_t   pending_accesses [$];
	pin_readback_t expected_readbacks [$];
	bus_access_t   current_access;

	int unsigned gap_left    = 0;
	int unsigned drive_style = 0;
	int unsigned drive_run   = 0;
	int unsigned stall_left  = 0;
	int unsigned sink_style  = 0;
	int unsigned sink_run    = 0;
	int unsigned idle_cycles = 0;
	int          mismatch_count = 0;

	initial begin
		for (int p = 0; p < MUX_PINS; p++) mux_func[p] = '0;
	end

	// wait length for one transaction: none, full range, or rare gaps
	function automatic int unsigned draw_wait(int unsigned style);
		case (style)
			0: return 0;
			1: return $urandom_range(0, 16);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
		endcase
	endfunction

	// apply one access to the shadow registers and form its result
	function automatic pin_readback_t predict_access(bus_access_t a);
		pin_readback_t     r;
		logic [DATA_W-1:0] rd;
		logic              bad;
		logic              is_wr;
		is_wr = (a.op == OP_WRITE);
		rd    = '0;
		bad   = 1'b0;
		if (a.region == RGN_MUX) begin
			if (a.word < MUX_PINS) begin
				if (is_wr) begin
					mux_func[a.word] = a.data[FUNC_W-1:0];
					mux_pd[a.word]   = a.data[MUX_PD_BIT];
					mux_pu[a.word]   = a.data[MUX_PU_BIT];
				end else begin
					rd[FUNC_W-1:0]  = mux_func[a.word];
					rd[MUX_PD_BIT]  = mux_pd[a.word];
					rd[MUX_PU_BIT]  = mux_pu[a.word];
				end
			end else begin
				bad = 1'b1;
			end
		end else begin
			case (a.word)
				W_OUT_LO:     if (is_wr) out_lo = a.data; else rd = out_lo;
				W_OUT_LO_SET: if (is_wr) out_lo = out_lo | a.data;
				W_OUT_LO_CLR: if (is_wr) out_lo = out_lo & ~a.data;
				W_OUT_HI:     if (is_wr) out_hi = a.data[HI_W-1:0]; else rd[HI_W-1:0] = out_hi;
				W_OUT_HI_SET: if (is_wr) out_hi = out_hi | a.data[HI_W-1:0];
				W_OUT_HI_CLR: if (is_wr) out_hi = out_hi & ~a.data[HI_W-1:0];
				W_OE_LO:      if (is_wr) oe_lo = a.data; else rd = oe_lo;
				W_OE_LO_SET:  if (is_wr) oe_lo = oe_lo | a.data;
				W_OE_LO_CLR:  if (is_wr) oe_lo = oe_lo & ~a.data;
				W_OE_HI:      if (is_wr) oe_hi = a.data[HI_W-1:0]; else rd[HI_W-1:0] = oe_hi;
				W_OE_HI_SET:  if (is_wr) oe_hi = oe_hi | a.data[HI_W-1:0];
				W_OE_HI_CLR:  if (is_wr) oe_hi = oe_hi & ~a.data[HI_W-1:0];
				W_IN_LO:      if (!is_wr) rd = a.pads[31:0];
				W_IN_HI:      if (!is_wr) rd[HI_W-1:0] = a.pads[PAD_W-1:32];
				default:      bad = 1'b1;
			endcase
		end
		if (is_wr) rd = '0;
		r.read_data   = rd;
		r.levels      = {out_hi, out_lo};
		r.enables     = {oe_hi, oe_lo};
		r.pullups     = mux_pu;
		r.pulldowns   = mux_pd;
		r.bad_address = bad;
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
			mismatch_count++;
		end
	endtask

	task automatic add_access(input access_op_e op, input access_region_e region,
			input logic [WORD_W-1:0] word, input logic [DATA_W-1:0] data,
			input logic [PAD_W-1:0] pads, input logic wait_drain);
		bus_access_t a;
		a.op         = op;
		a.region     = region;
		a.word       = word;
		a.data       = data;
		a.pads       = pads;
		a.wait_drain = wait_drain;
		pending_accesses.push_back(a);
	endtask

	function automatic logic [WORD_W-1:0] gpio_word(int unsigned idx);
		case (idx)
			0:  return W_OUT_LO;
			1:  return W_OUT_LO_SET;
			2:  return W_OUT_LO_CLR;
			3:  return W_OUT_HI;
			4:  return W_OUT_HI_SET;
			5:  return W_OUT_HI_CLR;
			6:  return W_OE_LO;
			7:  return W_OE_LO_SET;
			8:  return W_OE_LO_CLR;
			9:  return W_OE_HI;
			10: return W_OE_HI_SET;
			11: return W_OE_HI_CLR;
			12: return W_IN_LO;
			default: return W_IN_HI;
		endcase
	endfunction

	// mostly mapped words with random content, some unmapped noise
	task automatic add_random_access(input logic wait_drain);
		access_op_e        op;
		access_region_e    region;
		logic [WORD_W-1:0] word;
		logic [DATA_W-1:0] data;
		logic [PAD_W-1:0]  pads;
		int unsigned       pick;
		op   = ($urandom_range(0, 99) < 55) ? OP_WRITE : OP_READ;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			region = RGN_GPIO;
			word   = gpio_word($urandom_range(0, 13));
		end else if (pick < 90) begin
			region = RGN_MUX;
			word   = WORD_W'($urandom_range(0, MUX_PINS - 1));
		end else if (pick < 95) begin
			region = RGN_MUX;
			word   = WORD_W'($urandom_range(MUX_PINS, 63));
		end else begin
			region = RGN_GPIO;
			word   = WORD_W'($urandom_range(0, 63));
		end
		case ($urandom_range(0, 7))
			0: data = '0;
			1: data = '1;
			2: data = 32'd1 << $urandom_range(0, 31);
			default: data = $urandom;
		endcase
		pads = {8'($urandom_range(0, 255)), 32'($urandom)};
		add_access(op, region, word, data, pads, wait_drain);
	endtask

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// source side: one transaction per pending access, random gaps
	always @(posedge clk or negedge arst_n) begin : drive_proc
		bus_access_t next_access;
		logic        accepted;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			gap_left      <= 0;
		end else begin
			accepted = s_axis_tvalid && s_axis_tready;
			if (accepted)
				expected_readbacks.push_back(predict_access(current_access));
			if (s_axis_tvalid && !accepted) begin
				// transaction still offered
			end else if (gap_left != 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left      <= gap_left - 1;
			end else if (pending_accesses.size() != 0 &&
					!(pending_accesses[0].wait_drain && expected_readbacks.size() != 0)) begin
				next_access    = pending_accesses.pop_front();
				current_access <= next_access;
				s_axis_tvalid  <= 1'b1;
				s_axis_tdata   <= {2'b00, next_access.pads, next_access.data, next_access.word};
				s_axis_tuser   <= {next_access.region, next_access.op};
				gap_left       <= draw_wait(drive_style);
				if (drive_run == 0) begin
					drive_style <= $urandom_range(0, 2);
					drive_run   <= 31;
				end else begin
					drive_run <= drive_run - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// sink side: check each result, random stalls
	always @(posedge clk or negedge arst_n) begin : sink_proc
		pin_readback_t want;
		int unsigned   wait_n;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else begin
			wait_n = stall_left;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_readbacks.size() == 0) begin
					$error("result transaction with no access outstanding");
					mismatch_count++;
				end else begin
					want = expected_readbacks.pop_front();
					compare_field("read_data", want.read_data, m_axis_tdata[DATA_W-1:0]);
					compare_field("drive_levels", want.levels,
						m_axis_tdata[LEVEL_LSB +: LEVEL_W]);
					compare_field("drive_enables", want.enables,
						m_axis_tdata[ENABLE_LSB +: LEVEL_W]);
					compare_field("pullup_enables", want.pullups,
						m_axis_tdata[PU_LSB +: PULL_W]);
					compare_field("pulldown_enables", want.pulldowns,
						m_axis_tdata[PD_LSB +: PULL_W]);
					compare_field("bad_address", want.bad_address, m_axis_tuser[0]);
				end
				wait_n = draw_wait(sink_style);
				if (sink_run == 0) begin
					sink_style <= $urandom_range(0, 2);
					sink_run   <= 29;
				end else begin
					sink_run <= sink_run - 1;
				end
			end
			if (wait_n != 0) begin
				m_axis_tready <= 1'b0;
				stall_left    <= wait_n - 1;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left    <= 0;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_MAX) begin
				$display("Verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		// reset values, input words with pads at both extremes
		add_access(OP_READ,  RGN_GPIO, W_OUT_LO,     32'h0,         '1, 1'b0);
		add_access(OP_READ,  RGN_GPIO, W_IN_LO,      32'h0,         '1, 1'b0);
		add_access(OP_READ,  RGN_GPIO, W_IN_HI,      32'h0,         '1, 1'b0);
		add_access(OP_READ,  RGN_GPIO, W_IN_HI,      '1,            '0, 1'b0);
		// output words, high bank drops bits above the pin count
		add_access(OP_WRITE, RGN_GPIO, W_OUT_LO,     '1,            '0, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, W_OUT_HI,     '1,            '0, 1'b0);
		add_access(OP_READ,  RGN_GPIO, W_OUT_HI,     '1,            '0, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, W_OUT_LO_CLR, 32'h0000ffff,  '0, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, W_OUT_LO_SET, 32'h00000f0f,  '0, 1'b0);
		add_access(OP_READ,  RGN_GPIO, W_OUT_LO_SET, '1,            '0, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, W_OUT_HI_CLR, 32'hffffff0f,  '0, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, W_OUT_HI_SET, 32'h000001a0,  '0, 1'b0);
		// enable words
		add_access(OP_WRITE, RGN_GPIO, W_OE_LO,      32'ha5a5a5a5,  '0, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, W_OE_LO_SET,  32'h0000ffff,  '0, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, W_OE_LO_CLR,  32'hff000000,  '0, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, W_OE_HI,      '1,            '0, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, W_OE_HI_CLR,  32'h0000003c,  '0, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, W_OE_HI_SET,  32'h00000001,  '0, 1'b0);
		add_access(OP_READ,  RGN_GPIO, W_OE_HI_CLR,  32'h0,         '1, 1'b0);
		add_access(OP_READ,  RGN_GPIO, W_OE_LO,      32'h0,         '0, 1'b0);
		// writes to input words are dropped, unmapped words flag an error
		add_access(OP_WRITE, RGN_GPIO, W_IN_LO,      '1,            '1, 1'b0);
		add_access(OP_READ,  RGN_GPIO, 6'd0,         32'h0,         '1, 1'b0);
		add_access(OP_WRITE, RGN_GPIO, 6'd63,        '1,            '0, 1'b0);
		// mux words: last pin, unused bits, pins past the mux range
		add_access(OP_WRITE, RGN_MUX,  6'(MUX_PINS - 1), '1,        '0, 1'b0);
		add_access(OP_READ,  RGN_MUX,  6'(MUX_PINS - 1), 32'h0,     '0, 1'b0);
		add_access(OP_WRITE, RGN_MUX,  6'd0,         32'hffffff45,  '0, 1'b0);
		add_access(OP_READ,  RGN_MUX,  6'(MUX_PINS), 32'h0,         '0, 1'b0);
		add_access(OP_WRITE, RGN_MUX,  6'd63,        '1,            '0, 1'b0);
		for (int i = 0; i < RANDOM_N; i++)
			add_random_access(i == 0 || i == RANDOM_N / 2);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_accesses.size() != 0 || s_axis_tvalid || expected_readbacks.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
